>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro wraps one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ACM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ACM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/acm_pkg.sv
// Shared types, constants and the jet color table for the auto-ranged colormap.
// No dependencies; imported by all modules of the block.
`default_nettype none

package acm_pkg;

    // Default sizes
    localparam int TABLE_ROWS_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 24;

    // Jet table geometry
    localparam int JET_ROWS  = 64;
    localparam int JET_IDX_W = 6;
    localparam int LEVEL_W   = 5;
    localparam int LEVEL_MAX = 16;

    // Result item: three levels packed into 16 bits
    localparam int OUT_TDATA_W = 16;

    // Request kinds carried on tuser
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FRAME  = 1'b1;

    typedef struct packed {
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } jet_rgb_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Jet color of one table row, levels in sixteenths
    function automatic jet_rgb_t jet_color(input logic [JET_IDX_W-1:0] r);
        jet_rgb_t c;
        // red: off, ramp up, full, ramp down
        if (r < 6'd24)
            c.red = 5'd0;
        else if (r < 6'd40)
            c.red = 5'(r - 6'd23);
        else if (r < 6'd57)
            c.red = 5'd16;
        else
            c.red = 5'(7'd72 - {1'b0, r});
        // green: off, ramp up, full, ramp down, off
        if (r < 6'd8)
            c.green = 5'd0;
        else if (r < 6'd24)
            c.green = 5'(r - 6'd7);
        else if (r < 6'd41)
            c.green = 5'd16;
        else if (r < 6'd56)
            c.green = 5'(7'd56 - {1'b0, r});
        else
            c.green = 5'd0;
        // blue: ramp up from 9, full, ramp down, off
        if (r < 6'd8)
            c.blue = 5'(r + 6'd9);
        else if (r < 6'd25)
            c.blue = 5'd16;
        else if (r < 6'd40)
            c.blue = 5'(7'd40 - {1'b0, r});
        else
            c.blue = 5'd0;
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/acm_range.sv
// Running extremes and latched frame bound for the auto-ranged colormap.
// Depends on acm_pkg (imported for consistency of sizes).
`default_nettype none

module acm_range
    import acm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_upd,  // sample item accepted
    input  wire logic                          frame_upd,   // frame-start item accepted
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0]      frame_m      // range is [-frame_m, frame_m]
);

    logic signed [SAMPLE_BITS-1:0] high_reg, high_next;
    logic signed [SAMPLE_BITS-1:0] low_reg,  low_next;
    logic signed [SAMPLE_BITS-1:0] m_reg,    m_next;
    logic signed [SAMPLE_BITS:0]   neg_low;
    logic signed [SAMPLE_BITS:0]   high_ext;

    // -low can reach 2^(SAMPLE_BITS-1); one extra bit holds it
    assign neg_low  = -{low_reg[SAMPLE_BITS-1], low_reg};
    assign high_ext = {high_reg[SAMPLE_BITS-1], high_reg};

    always_comb
    begin
        high_next = high_reg;
        low_next  = low_reg;
        m_next    = m_reg;
        if (frame_upd)
        begin
            // symmetric bound, never above the running high
            if (high_ext < neg_low)
                m_next = high_reg;
            else
                m_next = neg_low[SAMPLE_BITS-1:0];
            high_next = '0;
            low_next  = '0;
        end
        else if (sample_upd)
        begin
            if (sample > high_reg)
                high_next = sample;
            else if (sample < low_reg)
                low_next = sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_reg <= '0;
            low_reg  <= '0;
            m_reg    <= '0;
        end
        else
        begin
            high_reg <= high_next;
            low_reg  <= low_next;
            m_reg    <= m_next;
        end
    end

    assign frame_m = m_reg;

endmodule

`default_nettype wire

>>> rtl/acm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on acm_pkg for the status struct.
`default_nettype none

module acm_div
    import acm_pkg::*;
#(
    parameter int XW = SAMPLE_BITS_DEF + 1,          // divisor width
    parameter int QB = $clog2(TABLE_ROWS_DEF + 1)    // quotient bits
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [XW+QB-1:0] dividend,  // must give a quotient below 2^QB
    input  wire logic [XW-1:0]    divisor,   // held stable while busy
    output div_stat_t             stat,
    output logic [QB-1:0]         quotient
);

    localparam int CW = $clog2(QB + 1);

    logic [XW-1:0] rem_reg, rem_next;
    logic [QB-1:0] low_reg, low_next;   // dividend bits still to shift in
    logic [QB-1:0] quo_reg, quo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [XW+1:0] diff;

    // trial subtract of the remainder with the next dividend bit
    assign diff = {1'b0, rem_reg, low_reg[QB-1]} - {2'b00, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // top part is already below the divisor
            rem_next  = dividend[XW+QB-1:QB];
            low_next  = dividend[QB-1:0];
            cnt_next  = CW'(QB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[XW+1])
                rem_next = diff[XW-1:0];
            else
                rem_next = {rem_reg[XW-2:0], low_reg[QB-1]};
            low_next = {low_reg[QB-2:0], 1'b0};
            quo_next = {quo_reg[QB-2:0], ~diff[XW+1]};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

>>> rtl/autoranged_jet_colormap.sv
// Auto-ranged jet colormap: sample items are colored against the range latched
// at the last frame start, while running extremes are gathered for the next frame.
// A frame-start item (tuser = 1) leaves the block idle and gives no result. A sample
// item passes through ST_MUL, ST_DIV and ST_OUT before the next item can be accepted;
// in ST_DIV the bit-serial divider splits the frame range into table rows, one
// quotient bit per cycle. Samples outside the range, or with an empty range, skip the
// divider and go from ST_MUL straight to ST_OUT. A finished color waits in an output
// register, so the next item is taken while it is unread.
// Depends on acm_pkg, acm_range and acm_div.
`default_nettype none

module autoranged_jet_colormap
    import acm_pkg::*;
#(
    parameter int TABLE_ROWS  = TABLE_ROWS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample_value
    input  wire logic                                 s_axis_tuser,  // req_type
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [OUT_TDATA_W-1:0]                    m_axis_tdata   // red, green, blue
);

    localparam int XW = SAMPLE_BITS + 1;
    localparam int QB = $clog2(TABLE_ROWS + 1);
    localparam int NW = XW + QB;
    localparam int RW = $clog2(TABLE_ROWS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } acm_state_t;

    typedef enum logic [1:0] {
        CLS_EMPTY,
        CLS_ABOVE,
        CLS_BELOW,
        CLS_INSIDE
    } acm_class_t;

    acm_state_t state_reg, state_next;
    acm_class_t cls_reg, cls_next;
    logic [XW-1:0] x_reg;
    jet_rgb_t      out_reg;
    logic          out_valid_reg, out_valid_next;

    logic                          s_acc;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] frame_m;
    logic signed [SAMPLE_BITS:0]   shifted;
    logic [XW-1:0]                 den;
    logic [NW-1:0]                 num;
    logic                          div_start;
    div_stat_t                     div_stat;
    logic [QB-1:0]                 quo;
    logic [RW-1:0]                 row;
    logic                          out_load;
    logic [JET_IDX_W-1:0]          jet_idx [TABLE_ROWS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign sample        = signed'(s_axis_tdata[SAMPLE_BITS-1:0]);

    acm_range #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_range (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_upd(s_acc && (s_axis_tuser == REQ_SAMPLE)),
        .frame_upd (s_acc && (s_axis_tuser == REQ_FRAME)),
        .sample    (sample),
        .frame_m   (frame_m)
    );

    // offset from the lower bound; negative means below the range
    assign shifted = {sample[SAMPLE_BITS-1], sample} + {frame_m[SAMPLE_BITS-1], frame_m};

    // classify the sample against the latched range
    always_comb
    begin
        if (frame_m == '0)
            cls_next = CLS_EMPTY;
        else if (sample > frame_m)
            cls_next = CLS_ABOVE;
        else if (shifted[SAMPLE_BITS])
            cls_next = CLS_BELOW;
        else
            cls_next = CLS_INSIDE;
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            cls_reg <= cls_next;
            x_reg   <= shifted[XW-1:0];
        end
    end

    // range width is 2M; dividend is offset times rows
    assign den       = {frame_m[SAMPLE_BITS-1:0], 1'b0};
    assign num       = NW'(x_reg) * NW'(TABLE_ROWS);
    assign div_start = (state_reg == ST_MUL) && (cls_reg == CLS_INSIDE);

    acm_div #(
        .XW(XW),
        .QB(QB)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(num),
        .divisor (den),
        .stat    (div_stat),
        .quotient(quo)
    );

    // sequencer
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && (s_axis_tuser == REQ_SAMPLE))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cls_reg == CLS_INSIDE)
                    state_next = ST_DIV;
                else
                    state_next = ST_OUT;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // table row; the lower bound would give row -1 and clamps to 0
    always_comb
    begin
        case (cls_reg)
            CLS_EMPTY:  row = RW'(TABLE_ROWS / 2 - 1);
            CLS_ABOVE:  row = RW'(TABLE_ROWS - 1);
            CLS_BELOW:  row = '0;
            CLS_INSIDE: row = (quo == '0) ? '0 : RW'(quo - QB'(1));
            default:    row = '0;
        endcase
    end

    // row to jet row, worked out at elaboration
    for (genvar g = 0; g < TABLE_ROWS; g++)
    begin : g_jet_idx
        localparam int JR = (g * JET_ROWS) / TABLE_ROWS;
        assign jet_idx[g] = JET_IDX_W'(JR);
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= jet_color(jet_idx[row]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg};

endmodule

`default_nettype wire

>>> rtl/acm_checker.sv
// Port-level checks for the auto-ranged colormap, bound to the top level.
// Depends on acm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module acm_checker
    import acm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input wire logic                             s_axis_tuser,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0]           m_axis_tdata
);

    logic s_acc;
    logic levels_ok;

    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign levels_ok = (m_axis_tdata[4:0] <= 5'(LEVEL_MAX))
                    && (m_axis_tdata[9:5] <= 5'(LEVEL_MAX))
                    && (m_axis_tdata[14:10] <= 5'(LEVEL_MAX))
                    && !m_axis_tdata[15];

    // a stalled color holds
    `ACM_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // every color has all three levels within LEVEL_MAX and clear padding
    `ACM_ASSERT_NOW(a_levels, clk, rst_n, m_axis_tvalid, levels_ok)

    // a frame start taken while no color is pending brings no color
    `ACM_ASSERT_NEXT(a_frame_silent, clk, rst_n, s_acc && s_axis_tuser && !m_axis_tvalid, !m_axis_tvalid)

    // a sample occupies the block for the cycle after acceptance
    `ACM_ASSERT_NEXT(a_sample_busy, clk, rst_n, s_acc && !s_axis_tuser && (s_axis_tdata != s_axis_tdata + 1'b1), !s_axis_tready)

endmodule

bind autoranged_jet_colormap acm_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_acm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
